// ===== rtl/ufe_pkg.sv =====
// ufe_pkg: shared types and constants of the union-find engine
// widths of node numbers, forest entries, results and codes
// no dependencies
package ufe_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int SIZE_W    = 11;
    localparam int RANK_W    = 4;
    localparam int CFG_W     = NODE_W;
    localparam int REG_IDX_W = 1;
    localparam int TDATA_W   = 24;

    localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_UNION_MODE = 1'd1;

    typedef logic [NODE_W-1:0] node_t;

    typedef enum logic {
        CMD_UNION = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef enum logic {
        MODE_SIZE = 1'b0,
        MODE_RANK = 1'b1
    } union_mode_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [SIZE_W-1:0] size;
        node_t             parent;
    } node_entry_t;

    localparam int ENTRY_W = $bits(node_entry_t);

    typedef struct packed {
        logic        we;
        node_t       addr;
        node_entry_t data;
    } ram_wr_t;

    typedef struct packed {
        node_t       node_count;
        union_mode_t union_mode;
    } cfg_t;

    typedef struct packed {
        logic  valid;
        node_t count;
    } restart_t;

    typedef struct packed {
        logic  merged;
        node_t root;
        node_t components;
        logic  all_connected;
        logic  bad_node;
    } result_t;

endpackage

// ===== rtl/ufe_ram.sv =====
// ufe_ram: simple dual-port synchronous ram, one write and one read port
// read data registered, old data on a same-address access
// no dependencies
module ufe_ram #(
    parameter int DATA_W = 25,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ufe_core.sv =====
// ufe_core: sequencer of the union-find engine
// root walks, path compression, linking, clearing sweep and component count
// depends on ufe_pkg; drives the forest ram in ufe_ram
module ufe_core
    import ufe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  restart_t    restart,
    input  logic        in_valid,
    output logic        in_ready,
    input  cmd_t        in_cmd,
    input  node_t       in_a,
    input  node_t       in_b,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res,
    output ram_wr_t     ram_wr,
    output node_t       ram_raddr,
    input  node_entry_t ram_rdata
);

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_FIND     = 8'b0000_0100,
        S_COMP     = 8'b0000_1000,
        S_START_B  = 8'b0001_0000,
        S_JOIN     = 8'b0010_0000,
        S_LINK_TOP = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    node_t       clr_cnt_reg, clr_cnt_next;
    node_t       cur_reg, cur_next;
    logic        side_reg, side_next;
    node_t       a_reg, a_next;
    node_t       b_reg, b_next;
    node_t       root_a_reg, root_a_next;
    node_t       root_b_reg, root_b_next;
    node_entry_t ea_reg, ea_next;
    node_entry_t eb_reg, eb_next;
    node_t       set_count_reg, set_count_next;
    result_t     res_reg, res_next;
    logic        clear_pend_reg, clear_pend_next;

    node_t             n;
    node_t             start_node;
    node_t             side_root;
    logic              in_bad;
    logic              top_is_b;
    node_t             top_node;
    node_t             low_node;
    node_entry_t       top_e;
    node_entry_t       low_e;
    node_entry_t       top_wr;
    logic [SIZE_W-1:0] sum_size;
    logic [RANK_W-1:0] up_rank;
    node_t             cnt_dec;

    assign n          = cfg.node_count;
    assign start_node = side_reg ? b_reg : a_reg;
    assign side_root  = side_reg ? root_b_reg : root_a_reg;
    assign in_bad     = (in_a == '0) || (in_b == '0) || (in_a > n) || (in_b > n);
    assign cnt_dec    = (set_count_reg != '0) ? set_count_reg - 1'b1 : '0;

    // link decision
    always_comb
    begin
        if (cfg.union_mode == MODE_RANK)
        begin
            top_is_b = ea_reg.rank < eb_reg.rank;
        end
        else
        begin
            top_is_b = ea_reg.size < eb_reg.size;
        end
        top_node = top_is_b ? root_b_reg : root_a_reg;
        low_node = top_is_b ? root_a_reg : root_b_reg;
        top_e    = top_is_b ? eb_reg : ea_reg;
        low_e    = top_is_b ? ea_reg : eb_reg;
        sum_size = top_e.size + low_e.size;
        if (!top_is_b && (ea_reg.rank == eb_reg.rank) && (ea_reg.rank != RANK_MAX))
        begin
            up_rank = ea_reg.rank + 1'b1;
        end
        else
        begin
            up_rank = top_e.rank;
        end
        top_wr.parent = top_node;
        top_wr.size   = (cfg.union_mode == MODE_SIZE) ? sum_size : top_e.size;
        top_wr.rank   = (cfg.union_mode == MODE_RANK) ? up_rank : top_e.rank;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cur_next        = cur_reg;
        side_next       = side_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        root_a_next     = root_a_reg;
        root_b_next     = root_b_reg;
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        set_count_next  = set_count_reg;
        res_next        = res_reg;
        clear_pend_next = clear_pend_reg;
        ram_raddr       = cur_reg;
        ram_wr.we       = 1'b0;
        ram_wr.addr     = cur_reg;
        ram_wr.data     = ram_rdata;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr.we          = 1'b1;
                ram_wr.addr        = clr_cnt_reg;
                ram_wr.data.parent = clr_cnt_reg;
                ram_wr.data.size   = SIZE_W'(1);
                ram_wr.data.rank   = '0;
                if (clr_cnt_reg == n)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = in_a;
                    b_next = in_b;
                    if (in_cmd == CMD_CLEAR)
                    begin
                        set_count_next         = n;
                        res_next.merged        = 1'b0;
                        res_next.root          = '0;
                        res_next.components    = n;
                        res_next.all_connected = (n == NODE_W'(1));
                        res_next.bad_node      = 1'b0;
                        clear_pend_next        = 1'b1;
                        state_next             = S_DONE;
                    end
                    else if (in_bad)
                    begin
                        res_next.merged        = 1'b0;
                        res_next.root          = '0;
                        res_next.components    = set_count_reg;
                        res_next.all_connected = (set_count_reg == NODE_W'(1));
                        res_next.bad_node      = 1'b1;
                        state_next             = S_DONE;
                    end
                    else
                    begin
                        ram_raddr  = in_a;
                        cur_next   = in_a;
                        side_next  = 1'b0;
                        state_next = S_FIND;
                    end
                end
            end
            S_FIND:
            begin
                if (ram_rdata.parent == cur_reg)
                begin
                    if (side_reg)
                    begin
                        root_b_next = cur_reg;
                        eb_next     = ram_rdata;
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                        ea_next     = ram_rdata;
                    end
                    if (start_node == cur_reg)
                    begin
                        state_next = side_reg ? S_JOIN : S_START_B;
                    end
                    else
                    begin
                        ram_raddr  = start_node;
                        cur_next   = start_node;
                        state_next = S_COMP;
                    end
                end
                else
                begin
                    ram_raddr = ram_rdata.parent;
                    cur_next  = ram_rdata.parent;
                end
            end
            S_COMP:
            begin
                ram_wr.we          = 1'b1;
                ram_wr.addr        = cur_reg;
                ram_wr.data.parent = side_root;
                if (ram_rdata.parent == side_root)
                begin
                    state_next = side_reg ? S_JOIN : S_START_B;
                end
                else
                begin
                    ram_raddr = ram_rdata.parent;
                    cur_next  = ram_rdata.parent;
                end
            end
            S_START_B:
            begin
                ram_raddr  = b_reg;
                cur_next   = b_reg;
                side_next  = 1'b1;
                state_next = S_FIND;
            end
            S_JOIN:
            begin
                if (root_a_reg == root_b_reg)
                begin
                    res_next.merged        = 1'b0;
                    res_next.root          = root_a_reg;
                    res_next.components    = set_count_reg;
                    res_next.all_connected = (set_count_reg == NODE_W'(1));
                    res_next.bad_node      = 1'b0;
                    state_next             = S_DONE;
                end
                else
                begin
                    ram_wr.we          = 1'b1;
                    ram_wr.addr        = low_node;
                    ram_wr.data        = low_e;
                    ram_wr.data.parent = top_node;
                    state_next         = S_LINK_TOP;
                end
            end
            S_LINK_TOP:
            begin
                ram_wr.we              = 1'b1;
                ram_wr.addr            = top_node;
                ram_wr.data            = top_wr;
                set_count_next         = cnt_dec;
                res_next.merged        = 1'b1;
                res_next.root          = top_node;
                res_next.components    = cnt_dec;
                res_next.all_connected = (cnt_dec == NODE_W'(1));
                res_next.bad_node      = 1'b0;
                state_next             = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    clr_cnt_next    = '0;
                    clear_pend_next = 1'b0;
                    state_next      = clear_pend_reg ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // node count rewrite restarts the sweep
        if (restart.valid)
        begin
            state_next      = S_CLEAR;
            clr_cnt_next    = '0;
            set_count_next  = restart.count;
            clear_pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            side_reg       <= 1'b0;
            set_count_reg  <= NODE_W'(MAX_NODES - 1);
            clear_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            side_reg       <= side_next;
            set_count_reg  <= set_count_next;
            clear_pend_reg <= clear_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        res_reg    <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    a_comp_no_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP && ram_rdata.parent != side_root) |-> (ram_raddr != ram_wr.addr))
        else $error("compression reads the entry it writes");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (set_count_reg <= n))
        else $error("component count above node count");

    a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK_TOP) |-> (root_a_reg != root_b_reg))
        else $error("linking a root under itself");

    a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK_TOP && set_count_reg != '0 && !restart.valid)
        |=> (set_count_reg == $past(set_count_reg) - 1'b1))
        else $error("merge did not lower the component count");

endmodule

// ===== rtl/union_find_engine.sv =====
// union find engine: a union walks from node a to its root and compresses that path, does the same for b,
// then links the lower root under the top one and updates the top entry (no link when both roots match)
// one item at a time, the walk through the forest ram moving one level per cycle
// a clear or bad-node beat goes straight to the done state; a clear then sweeps
// node_count + 1 entries, as do reset (1024 entries) and a node_count write, no beat taken
// configuration registers come up as node_count 1023, union_mode 0; depends on ufe_pkg
module union_find_engine
    import ufe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,  // node_a, node_b
    input  logic                 s_axis_tuser,  // cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,  // merged, root, components, all_connected
    output logic                 m_axis_tuser   // bad_node
);

    node_t       node_count_reg, node_count_next;
    union_mode_t union_mode_reg, union_mode_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;

    cfg_t        cfg;
    restart_t    restart;
    logic        res_valid;
    logic        res_ready;
    result_t     res;
    ram_wr_t     ram_wr;
    node_t       ram_raddr;
    node_entry_t ram_rdata;

    always_comb
    begin
        node_count_next = node_count_reg;
        union_mode_next = union_mode_reg;
        if (cfg_we && cfg_index == REG_NODE_COUNT)
        begin
            node_count_next = cfg_data[NODE_W-1:0];
        end
        else if (cfg_we && cfg_index == REG_UNION_MODE)
        begin
            union_mode_next = union_mode_t'(cfg_data[0]);
        end
    end

    assign restart.valid  = cfg_we && (cfg_index == REG_NODE_COUNT);
    assign restart.count  = cfg_data[NODE_W-1:0];
    assign cfg.node_count = node_count_reg;
    assign cfg.union_mode = union_mode_reg;

    // output register
    assign res_ready      = !out_valid_reg || m_axis_tready;
    assign out_valid_next = res_valid || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_W'(MAX_NODES - 1);
            union_mode_reg <= MODE_SIZE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            union_mode_reg <= union_mode_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    ufe_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .restart   (restart),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (cmd_t'(s_axis_tuser)),
        .in_a      (s_axis_tdata[NODE_W-1:0]),
        .in_b      (s_axis_tdata[2*NODE_W-1:NODE_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_wr    (ram_wr),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ufe_ram #(
        .DATA_W (ENTRY_W),
        .ADDR_W (NODE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - 2*NODE_W - 2){1'b0}}, out_reg.all_connected,
                            out_reg.components, out_reg.root, out_reg.merged};
    assign m_axis_tuser  = out_reg.bad_node;

endmodule

// ===== test/union_find_engine_tb.sv =====
// union_find_engine_tb: self-checking bench for the union-find engine
// a queue-fed stream driver, a result monitor and a disjoint-set predictor
// depends on ufe_pkg and union_find_engine
module union_find_engine_tb;
    import ufe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE      = 1100;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        cmd_t  cmd;
        node_t a;
        node_t b;
    } union_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tuser;

    union_find_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // predictor state
    node_t             forest_parent [MAX_NODES];
    logic [SIZE_W-1:0] forest_size   [MAX_NODES];
    logic [RANK_W-1:0] forest_rank   [MAX_NODES];
    node_t             set_count;
    node_t             live_nodes;
    union_mode_t       join_mode;

    union_req_t pending_reqs [$];
    result_t    expected_results [$];

    int  total_queued = 0;
    int  results_seen = 0;
    int  failures = 0;
    int  cycles = 0;
    int  merges_seen = 0;
    int  bad_seen = 0;
    int  clears_seen = 0;
    bit  steady = 1'b0;
    bit  in_taken = 1'b0;

    result_t    want;
    result_t    got;
    union_req_t drive_req;

    function automatic void clear_forest();
        for (int i = 0; i < MAX_NODES; i++)
        begin
            forest_parent[i] = node_t'(i);
            forest_size[i]   = SIZE_W'(1);
            forest_rank[i]   = '0;
        end
        set_count = live_nodes;
    endfunction

    function automatic node_t find_and_compress(node_t x);
        node_t r;
        node_t nxt;
        node_t cur;
        int    steps;
        r = x;
        steps = 0;
        while (steps < MAX_NODES)
        begin
            nxt = forest_parent[r];
            if (nxt == r)
                break;
            r = nxt;
            steps++;
        end
        cur = x;
        steps = 0;
        while (cur != r && steps < MAX_NODES)
        begin
            nxt = forest_parent[cur];
            forest_parent[cur] = r;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic result_t predict_union(cmd_t cmd, node_t a, node_t b);
        result_t res;
        node_t   ra;
        node_t   rb;
        node_t   top;
        node_t   low;
        res = '0;
        if (cmd == CMD_CLEAR)
            clear_forest();
        else if (a == 0 || b == 0 || a > live_nodes || b > live_nodes)
            res.bad_node = 1'b1;
        else
        begin
            ra = find_and_compress(a);
            rb = find_and_compress(b);
            if (ra == rb)
                res.root = ra;
            else
            begin
                if (join_mode == MODE_SIZE)
                begin
                    if (forest_size[ra] < forest_size[rb])
                    begin
                        top = rb;
                        low = ra;
                    end
                    else
                    begin
                        top = ra;
                        low = rb;
                    end
                    forest_size[top] = forest_size[top] + forest_size[low];
                end
                else
                begin
                    if (forest_rank[ra] < forest_rank[rb])
                    begin
                        top = rb;
                        low = ra;
                    end
                    else
                    begin
                        top = ra;
                        low = rb;
                        if (forest_rank[ra] == forest_rank[rb] && forest_rank[ra] < RANK_MAX)
                            forest_rank[ra] = forest_rank[ra] + 1'b1;
                    end
                end
                forest_parent[low] = top;
                if (set_count > 0)
                    set_count = set_count - 1'b1;
                res.merged = 1'b1;
                res.root = top;
            end
        end
        res.components = set_count;
        res.all_connected = (set_count == 1);
        return res;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            failures++;
        end
    endtask

    // monitor: result beats checked first, then accepted request beats predicted
    always @(posedge clk)
    begin
        cycles++;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    got.merged        = m_axis_tdata[0];
                    got.root          = m_axis_tdata[NODE_W:1];
                    got.components    = m_axis_tdata[2*NODE_W:NODE_W+1];
                    got.all_connected = m_axis_tdata[2*NODE_W+1];
                    got.bad_node      = m_axis_tuser;
                    check_field("merged", int'(want.merged), int'(got.merged));
                    check_field("root", int'(want.root), int'(got.root));
                    check_field("components", int'(want.components), int'(got.components));
                    check_field("all_connected", int'(want.all_connected),
                                int'(got.all_connected));
                    check_field("bad_node", int'(want.bad_node), int'(got.bad_node));
                    results_seen++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = predict_union(cmd_t'(s_axis_tuser), s_axis_tdata[NODE_W-1:0],
                                     s_axis_tdata[2*NODE_W-1:NODE_W]);
                if (cmd_t'(s_axis_tuser) == CMD_CLEAR)
                    clears_seen++;
                if (want.merged)
                    merges_seen++;
                if (want.bad_node)
                    bad_seen++;
                expected_results.push_back(want);
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // driver: request beats from the pending queue, random back-pressure on results
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= 34))
            begin
                drive_req = pending_reqs.pop_front();
                s_axis_tdata  <= {{(TDATA_W-2*NODE_W){1'b0}}, drive_req.b, drive_req.a};
                s_axis_tuser  <= drive_req.cmd;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= steady || ($urandom_range(99) >= 34);
    end

    task automatic queue_req(cmd_t cmd, int a, int b);
        union_req_t r;
        r.cmd = cmd;
        r.a = node_t'(a);
        r.b = node_t'(b);
        pending_reqs.push_back(r);
        total_queued++;
    endtask

    // every result in and any clear sweep finished
    task automatic wait_idle();
        while (results_seen != total_queued)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        if (idx == REG_NODE_COUNT)
        begin
            live_nodes = node_t'(value);
            clear_forest();
        end
        else
            join_mode = union_mode_t'(value[0]);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int bad_value(int n);
        if (n < MAX_NODES - 1 && $urandom_range(1))
            return $urandom_range(MAX_NODES - 1, n + 1);
        return 0;
    endfunction

    task automatic queue_random(int n);
        int pick;
        int sel;
        int a;
        int b;
        pick = $urandom_range(99);
        if (n == 0)
        begin
            a = $urandom_range(MAX_NODES - 1);
            b = $urandom_range(MAX_NODES - 1);
        end
        else
        begin
            a = $urandom_range(n, 1);
            b = $urandom_range(n, 1);
        end
        if (pick < 1)
            queue_req(CMD_CLEAR, $urandom_range(MAX_NODES - 1), $urandom_range(MAX_NODES - 1));
        else if (pick < 9)
        begin
            sel = $urandom_range(2);
            if (sel != 1)
                a = bad_value(n);
            if (sel != 0)
                b = bad_value(n);
            queue_req(CMD_UNION, a, b);
        end
        else
            queue_req(CMD_UNION, a, b);
    endtask

    task automatic random_phase(int n, union_mode_t mode, int count, bit calm);
        write_reg(REG_NODE_COUNT, n);
        write_reg(REG_UNION_MODE, int'(mode));
        steady = calm;
        repeat (count) queue_random(n);
    endtask

    initial
    begin
        live_nodes = 10'd1023;
        join_mode = MODE_SIZE;
        clear_forest();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: ties, same root, extremes, bad nodes, clear
        queue_req(CMD_UNION, 1, 2);
        queue_req(CMD_UNION, 3, 1);
        queue_req(CMD_UNION, 2, 3);
        queue_req(CMD_UNION, 7, 7);
        queue_req(CMD_UNION, 1023, 1022);
        queue_req(CMD_UNION, 0, 5);
        queue_req(CMD_UNION, 5, 0);
        queue_req(CMD_UNION, 0, 0);
        queue_req(CMD_UNION, 682, 341);
        queue_req(CMD_UNION, 341, 682);
        queue_req(CMD_CLEAR, 1023, 1023);
        queue_req(CMD_UNION, 1, 2);

        // tiny forest by rank, up to fully connected
        write_reg(REG_NODE_COUNT, 4);
        write_reg(REG_UNION_MODE, int'(MODE_RANK));
        queue_req(CMD_UNION, 1, 2);
        queue_req(CMD_UNION, 3, 4);
        queue_req(CMD_UNION, 1, 3);
        queue_req(CMD_UNION, 5, 1);
        queue_req(CMD_UNION, 1, 1023);
        queue_req(CMD_UNION, 2, 4);
        queue_req(CMD_UNION, 4, 2);

        write_reg(REG_NODE_COUNT, 1);
        queue_req(CMD_UNION, 1, 1);
        queue_req(CMD_UNION, 1, 2);

        write_reg(REG_NODE_COUNT, 0);
        queue_req(CMD_UNION, 1, 1);
        queue_req(CMD_CLEAR, 0, 0);

        random_phase(16, MODE_SIZE, 150, 1'b0);
        random_phase(16, MODE_RANK, 150, 1'b0);
        random_phase(1023, MODE_SIZE, 250, 1'b0);
        random_phase(1023, MODE_RANK, 250, 1'b0);
        random_phase(64, MODE_RANK, 200, 1'b1);
        random_phase(200, MODE_SIZE, 200, 1'b0);
        random_phase(5, MODE_SIZE, 100, 1'b0);
        random_phase(1, MODE_RANK, 50, 1'b0);
        random_phase(0, MODE_SIZE, 30, 1'b0);
        random_phase(40, MODE_RANK, 200, 1'b0);
        random_phase(500, MODE_RANK, 120, 1'b0);

        wait_idle();
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            failures++;
        end
        $display("checked %0d results over node counts 0 to 1023 in size and rank mode",
                 results_seen);
        $display("%0d merges, %0d bad-node requests, %0d clears, %0d mismatches",
                 merges_seen, bad_seen, clears_seen, failures);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
